/* rtl/core/p2ah_pkg.sv */
`timescale 1ns / 1ps
package p2ah_pkg;

   // widths of the external fields
   localparam int IN_W    = 16;
   localparam int SP_W    = 20;
   localparam int RAD_W   = 10;
   localparam int OUT_W   = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   // precision of the cube constants
   localparam int FRAC_BITS    = 16;
   localparam int SPACING_FRAC = 16;
   localparam int TOT_FRAC     = SPACING_FRAC + FRAC_BITS;

   // internal datapath widths
   localparam int DX_W   = IN_W + 1;
   localparam int PX_W   = DX_W + SP_W + 1;
   localparam int K_W    = FRAC_BITS + 2;
   localparam int PROD_W = PX_W + K_W;
   localparam int CUBE_W = PROD_W + 2;
   localparam int INT_W  = CUBE_W - TOT_FRAC + 1;
   localparam int HEX_W  = INT_W + 1;

   localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
   localparam int OUT_MIN = -(2 ** (OUT_W - 1));

   // sqrt3/3, 1/3, 2/3 as Q0.32, truncated
   localparam logic [31:0] K32_SQ3   = 32'd2479700524;
   localparam logic [31:0] K32_THIRD = 32'd1431655765;
   localparam logic [31:0] K32_TWO3  = 32'd2863311530;

   // round a Q0.32 constant half up to Q0.FRAC_BITS
   function automatic logic [FRAC_BITS:0] qconst(input logic [31:0] k32);
      logic [32:0] sum;
      sum = {1'b0, k32} + (33'd1 << (32 - FRAC_BITS - 1));
      return (FRAC_BITS + 1)'(sum >> (32 - FRAC_BITS));
   endfunction

   localparam logic signed [K_W-1:0] C_SQ3   = K_W'(qconst(K32_SQ3));
   localparam logic signed [K_W-1:0] C_THIRD = K_W'(qconst(K32_THIRD));
   localparam logic signed [K_W-1:0] C_TWO3  = K_W'(qconst(K32_TWO3));

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPACING_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPACING_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEX_RADIUS    = 3'd4;

   localparam logic [SP_W-1:0]  INV_SPACING_RST = 20'd65536;
   localparam logic [RAD_W-1:0] HEX_RADIUS_RST  = 10'd16;

   typedef struct packed {
      logic signed [IN_W-1:0] point_x;
      logic signed [IN_W-1:0] point_y;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] hex_q;
      logic signed [OUT_W-1:0] hex_r;
      logic                    in_map;
   } rsp_word_type;

endpackage

/* rtl/core/pixel_to_axial_hex.sv */
`timescale 1ns / 1ps
// Pixel to pointy-top hex cell. Each request word carries one screen point;
// each response word carries the axial cell (hex_q, hex_r) that holds it,
// saturated to 12 bits, and in_map, set when |q|, |r| and |s| are all within
// the configured map radius (a saturated cell is never in the map). The point
// is offset by origin_x/y and scaled by inv_spacing_x/y (unsigned Q4.16), then
// turned into fractional cube coordinates with Q0.16 constants, rounded half
// away from zero, and the component with the largest rounding error is rebuilt
// from the other two. Throughput is one word per clock when the response side
// does not stall. Seven register stages: origin subtract, spacing multiply,
// cube constant multiply, cube sum, rounding, rebuild, and saturate/range
// check. The first stage loads at the request accept edge; each word then
// passes the stages in order, and response valid rises as it enters the last.
// Stall from the response side backs up only as far as the first empty stage,
// so bubbles are squeezed out. Registers are written through the csr port,
// which is always ready; writes should happen only while the pipeline is
// empty. Unknown register indexes are ignored.
module pixel_to_axial_hex
   import p2ah_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NSTG = 7;

   typedef struct packed {
      logic signed [INT_W-1:0] val;
      logic [TOT_FRAC-1:0]     err;
   } rnd_type;

   // round half away from zero at TOT_FRAC bits, keep |error|
   function automatic rnd_type round_cube(input logic signed [CUBE_W-1:0] v);
      logic [CUBE_W-1:0]       mag;
      logic [CUBE_W-1:0]       sum;
      logic [TOT_FRAC-1:0]     f;
      logic [INT_W-2:0]        rm;
      rnd_type                 res;
      mag = v[CUBE_W-1] ? CUBE_W'(-v) : CUBE_W'(v);
      f   = mag[TOT_FRAC-1:0];
      sum = mag + (CUBE_W'(1) << (TOT_FRAC - 1));
      rm  = sum[CUBE_W-1:TOT_FRAC];
      res.val = v[CUBE_W-1] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
      // one - f wraps to -f since f is nonzero there
      res.err = f[TOT_FRAC-1] ? TOT_FRAC'(0) - f : f;
      return res;
   endfunction

   // ---------------- configuration registers ----------------
   logic signed [IN_W-1:0] origin_x_ff, origin_y_ff;
   logic [SP_W-1:0]        inv_x_ff, inv_y_ff;
   logic [RAD_W-1:0]       radius_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         inv_x_ff    <= INV_SPACING_RST;
         inv_y_ff    <= INV_SPACING_RST;
         radius_ff   <= HEX_RADIUS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_X:      origin_x_ff <= csr_wdata[IN_W-1:0];
            CSR_ORIGIN_Y:      origin_y_ff <= csr_wdata[IN_W-1:0];
            CSR_INV_SPACING_X: inv_x_ff    <= csr_wdata[SP_W-1:0];
            CSR_INV_SPACING_Y: inv_y_ff    <= csr_wdata[SP_W-1:0];
            CSR_HEX_RADIUS:    radius_ff   <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   // a stage loads when it is empty or its successor loads
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] load;
   logic [NSTG-1:0] valid_in;

   always_comb begin
      load[NSTG-1] = !valid_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in = {valid_ff[NSTG-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NSTG-1];

   // ---------------- stage 0: origin offset ----------------
   logic signed [DX_W-1:0] dx_ff, dy_ff, dx_in, dy_in;

   assign dx_in = DX_W'(req_data.point_x) - DX_W'(origin_x_ff);
   assign dy_in = DX_W'(req_data.point_y) - DX_W'(origin_y_ff);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // ---------------- stage 1: spacing scale, Q.16 ----------------
   logic signed [SP_W:0]   inv_x_s, inv_y_s;
   logic signed [PX_W-1:0] px_ff, py_ff, px_in, py_in;

   assign inv_x_s = $signed({1'b0, inv_x_ff});
   assign inv_y_s = $signed({1'b0, inv_y_ff});
   assign px_in   = PX_W'(dx_ff) * PX_W'(inv_x_s);
   assign py_in   = PX_W'(dy_ff) * PX_W'(inv_y_s);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // ---------------- stage 2: cube constant products ----------------
   logic signed [PROD_W-1:0] pa_ff, pb_ff, pc_ff, pa_in, pb_in, pc_in;

   assign pa_in = PROD_W'(px_ff) * PROD_W'(C_SQ3);
   assign pb_in = PROD_W'(py_ff) * PROD_W'(C_THIRD);
   assign pc_in = PROD_W'(py_ff) * PROD_W'(C_TWO3);

   always_ff @(posedge clock) begin
      if (load[2]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         pc_ff <= pc_in;
      end
   end

   // ---------------- stage 3: fractional cube coords ----------------
   logic signed [CUBE_W-1:0] qf_ff, rf_ff, sf_ff, qf_in, rf_in, sf_in;

   assign qf_in = CUBE_W'(pa_ff) - CUBE_W'(pb_ff);
   assign rf_in = CUBE_W'(pc_ff);
   // s = -q - r = b - a - c
   assign sf_in = CUBE_W'(pb_ff) - CUBE_W'(pa_ff) - CUBE_W'(pc_ff);

   always_ff @(posedge clock) begin
      if (load[3]) begin
         qf_ff <= qf_in;
         rf_ff <= rf_in;
         sf_ff <= sf_in;
      end
   end

   // ---------------- stage 4: rounding ----------------
   rnd_type rq_ff, rr_ff, rs_ff;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         rq_ff <= round_cube(qf_ff);
         rr_ff <= round_cube(rf_ff);
         rs_ff <= round_cube(sf_ff);
      end
   end

   // ---------------- stage 5: rebuild worst component ----------------
   logic signed [HEX_W-1:0] hq_ff, hr_ff, hq_in, hr_in;
   logic signed [HEX_W-1:0] qx, rx, sx;
   logic                    drop_q, drop_r;

   always_comb begin
      qx = HEX_W'(rq_ff.val);
      rx = HEX_W'(rr_ff.val);
      sx = HEX_W'(rs_ff.val);
      // q wins only on a strict maximum; r beats s only strictly
      drop_q = (rq_ff.err > rr_ff.err) && (rq_ff.err > rs_ff.err);
      drop_r = !drop_q && (rr_ff.err > rs_ff.err);
      hq_in  = drop_q ? -rx - sx : qx;
      hr_in  = drop_r ? -qx - sx : rx;
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         hq_ff <= hq_in;
         hr_ff <= hr_in;
      end
   end

   // ---------------- stage 6: saturate and map range ----------------
   logic signed [HEX_W:0]   cs;
   logic signed [HEX_W:0]   rad_s;
   logic signed [HEX_W-1:0] oq, orr;
   logic                    sat, in_range;
   rsp_word_type            rsp_data_ff, rsp_data_in;

   always_comb begin
      sat = 1'b0;
      oq  = hq_ff;
      orr = hr_ff;
      if (hq_ff < OUT_MIN) begin
         sat = 1'b1;
         oq  = HEX_W'(OUT_MIN);
      end else if (hq_ff > OUT_MAX) begin
         sat = 1'b1;
         oq  = HEX_W'(OUT_MAX);
      end
      if (hr_ff < OUT_MIN) begin
         sat = 1'b1;
         orr = HEX_W'(OUT_MIN);
      end else if (hr_ff > OUT_MAX) begin
         sat = 1'b1;
         orr = HEX_W'(OUT_MAX);
      end
      cs       = -(HEX_W + 1)'(hq_ff) - (HEX_W + 1)'(hr_ff);
      rad_s    = $signed({{(HEX_W + 1 - RAD_W){1'b0}}, radius_ff});
      in_range = !sat
                 && ((HEX_W + 1)'(hq_ff) <= rad_s) && ((HEX_W + 1)'(hq_ff) >= -rad_s)
                 && ((HEX_W + 1)'(hr_ff) <= rad_s) && ((HEX_W + 1)'(hr_ff) >= -rad_s)
                 && (cs <= rad_s) && (cs >= -rad_s);
      rsp_data_in.hex_q  = oq[OUT_W-1:0];
      rsp_data_in.hex_r  = orr[OUT_W-1:0];
      rsp_data_in.in_map = in_range;
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

/* rtl/core/p2ah_checker.sv */
`timescale 1ns / 1ps
module p2ah_checker
   import p2ah_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // held response word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // open output means the whole pipe advances
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled with open output");

   // an in-map cell has all cube coords within the largest radius
   a_in_map_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_map |->
         rsp_data.hex_q >= -1023 && rsp_data.hex_q <= 1023
         && rsp_data.hex_r >= -1023 && rsp_data.hex_r <= 1023
         && (rsp_data.hex_q + rsp_data.hex_r) >= -1023
         && (rsp_data.hex_q + rsp_data.hex_r) <= 1023)
      else $error("in_map set on cell outside range");

endmodule

bind pixel_to_axial_hex p2ah_checker u_p2ah_checker (.*);
